[hdl/step_sequencer_note_engine_unit_assert.svh]
// Assertion helpers for the engine's top module.
// Each expects clk and arst_n in the scope of the module that uses it.
`ifndef STEP_SEQUENCER_NOTE_ENGINE_UNIT_ASSERT_SVH
`define STEP_SEQUENCER_NOTE_ENGINE_UNIT_ASSERT_SVH

// Property must hold at every clock edge outside reset
`define SSNE_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Condition must never be seen at a clock edge outside reset
`define SSNE_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

[hdl/ssne_pkg.sv]
package ssne_pkg;

	// Input item
	typedef struct packed {
		logic [2:0]  mode;
		logic [7:0]  step_number;
		logic [11:0] sensor_mm;
		logic        hold_note;
		logic        hold_velocity;
		logic        hold_filter;
		logic        edit_active;
		logic        gate_in;
		logic        slide_in;
		logic [4:0]  note_in;
		logic [6:0]  velocity_in;
		logic [12:0] data_value;
	} in_t;

	// Result item
	typedef struct packed {
		logic        note_on;
		logic        note_off;
		logic [6:0]  midi_note;
		logic [6:0]  velocity_out;
		logic [12:0] filter_out;
		logic        gate_out;
		logic        slide_out;
		logic [4:0]  note_index;
		logic [3:0]  playhead_out;
		logic [1:0]  status;
	} out_t;

	// One pattern step
	typedef struct packed {
		logic        gate;
		logic        slide;
		logic [4:0]  note;
		logic [6:0]  velocity;
		logic [12:0] filter;
	} step_t;

	// Write strobes into the step store
	typedef struct packed {
		logic all;
		logic note;
		logic vel;
		logic filt;
		logic tgl;
	} step_wr_t;

	// Item modes
	localparam logic [2:0] MODE_CLOCK  = 3'd0;
	localparam logic [2:0] MODE_TICK   = 3'd1;
	localparam logic [2:0] MODE_WRITE  = 3'd2;
	localparam logic [2:0] MODE_TOGGLE = 3'd3;
	localparam logic [2:0] MODE_SCALE  = 3'd4;

	// Status codes
	localparam logic [1:0] STATUS_OK        = 2'd0;
	localparam logic [1:0] STATUS_BAD_INDEX = 2'd1;
	localparam logic [1:0] STATUS_BAD_VALUE = 2'd2;

	// Configuration register indexes
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 5;
	localparam logic [CFG_IDX_W-1:0] REG_STEP_LENGTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SCALE_SELECT = 2'd1;
	localparam logic [4:0] STEP_LENGTH_RESET = 5'd16;

	// Step reset contents
	localparam logic [6:0]  VEL_RESET  = 7'd100;
	localparam logic [12:0] FILT_RESET = 13'd2000;

	// Note timing and pitch
	localparam logic [4:0] NOTE_TICKS = 5'd24;
	localparam logic [8:0] BASE_NOTE  = 9'd36;
	localparam logic [8:0] MIDI_MAX   = 9'd127;
	localparam logic [4:0] NOTE_MAX   = 5'd24;
	localparam int SCALE_VAL_MAX = 255;

	// Shared divider geometry
	localparam int DIV_DW = 24;
	localparam int DIV_VW = 11;

	// Sensor mapping: mm * k / 1400 with clamps
	localparam logic [11:0] SENSOR_DIV    = 12'd1400;
	localparam logic [11:0] MUL_NOTE      = 12'd24;
	localparam logic [11:0] MUL_VEL       = 12'd127;
	localparam logic [11:0] MUL_FILT      = 12'd4000;
	localparam logic [12:0] FILT_LIMIT    = 13'd5000;
	localparam logic [12:0] FILT_FALLBACK = 13'd4000;
	localparam logic [6:0]  VEL_MAX       = 7'd127;

endpackage

[hdl/ssne_div.sv]
module ssne_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [ssne_pkg::DIV_DW-1:0] dividend,
	input  logic [ssne_pkg::DIV_VW-1:0] divisor,
	output logic                       done,
	output logic [ssne_pkg::DIV_DW-1:0] quotient,
	output logic [ssne_pkg::DIV_VW-1:0] remainder
);
	import ssne_pkg::*;

	localparam int CW = $clog2(DIV_DW + 1);

	logic [CW-1:0]     cnt_q;
	logic              done_q;
	logic [DIV_DW-1:0] quo_q;
	logic [DIV_VW-1:0] rem_q;
	logic [DIV_VW-1:0] div_q;
	logic [DIV_VW:0]   trial;
	logic              fits;

	// One restoring step: bring down the next dividend bit and try the subtract
	always_comb begin
		trial = {rem_q, quo_q[DIV_DW-1]};
		fits  = trial >= {1'b0, div_q};
	end

	// Iteration count and completion pulse
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else if (start) begin
			cnt_q  <= CW'(DIV_DW);
			done_q <= 1'b0;
		end else if (cnt_q != '0) begin
			cnt_q  <= cnt_q - 1'b1;
			done_q <= (cnt_q == CW'(1));
		end else begin
			done_q <= 1'b0;
		end
	end

	// Partial remainder and quotient shift register
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			div_q <= divisor;
		end else if (cnt_q != '0) begin
			if (fits) begin
				rem_q <= DIV_VW'(trial - {1'b0, div_q});
			end else begin
				rem_q <= trial[DIV_VW-1:0];
			end
			quo_q <= {quo_q[DIV_DW-2:0], fits};
		end
	end

	assign done      = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;

endmodule

[hdl/ssne_steps.sv]
module ssne_steps #(
	parameter int MAX_STEPS = 16,
	parameter int PW = 4
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [PW-1:0]      addr,
	input  ssne_pkg::step_wr_t wr,
	input  ssne_pkg::step_t    wdata,
	output ssne_pkg::step_t    rdata
);
	import ssne_pkg::*;

	step_t steps_q [MAX_STEPS];

	// Hold the pattern; all writes go to the one addressed step
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_STEPS; i++) begin
				steps_q[i] <= '{gate: 1'b1, slide: 1'b0, note: '0,
					velocity: VEL_RESET, filter: FILT_RESET};
			end
		end else begin
			if (wr.all) begin
				steps_q[addr] <= wdata;
			end
			if (wr.note) begin
				steps_q[addr].note <= wdata.note;
			end
			if (wr.vel) begin
				steps_q[addr].velocity <= wdata.velocity;
			end
			if (wr.filt) begin
				steps_q[addr].filter <= wdata.filter;
			end
			if (wr.tgl) begin
				steps_q[addr].gate <= ~steps_q[addr].gate;
			end
		end
	end

	assign rdata = steps_q[addr];

endmodule

[hdl/ssne_scale.sv]
module ssne_scale #(
	parameter int DEPTH = 240,
	parameter int AW = 8
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [7:0]    wdata,
	input  logic [AW-1:0] raddr,
	output logic [7:0]    rdata
);

	logic [7:0] mem [DEPTH];
	logic [7:0] rdata_q;

	// Single write port, registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

[hdl/step_sequencer_note_engine_unit.sv]
// Monophonic step sequencer note engine.
// Input channel in_valid/in_ready/in_data carries one item (clock step, tick,
// step write, gate toggle or scale entry write); each transfer produces exactly
// one result on out_valid/out_ready/out_data. Configuration (step length, scale
// row) is written over cfg_valid/cfg_ready/cfg_index/cfg_data; the user must
// write it only while idle, and the block itself does not enforce it. The port is always ready.
// Items are processed one at a time by a small sequencer around one shared
// 24-step restoring divider (modulo by the pattern length, and the divide by
// 1400 of the sensor mapping) plus one 12x12 multiplier.
// Tick and edit items finish without the divider; a clock step runs the length
// modulo and then one multiply and sensor divide for each held button that maps
// the sensor into the step. in_ready rises again the cycle after the result is loaded.
// The result sits in an output register; the next item is taken while it waits.
// If the receiver stalls, a finished item holds in its last state until the
// output register frees up, and no new item is taken meanwhile.
// Reset restores the default pattern (all gated, velocity 100, filter 2000),
// playhead 0, no note sounding, length 16, scale row 0. The scale memory has
// no reset and must be written before it is used.
module step_sequencer_note_engine_unit #(
	parameter int MAX_STEPS = 16,
	parameter int SCALE_LEN = 48,
	parameter int NUM_SCALES = 5
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  ssne_pkg::in_t                      in_data,
	output logic                               out_valid,
	input  logic                               out_ready,
	output ssne_pkg::out_t                     out_data,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [ssne_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [ssne_pkg::CFG_DATA_W-1:0]    cfg_data
);
	import ssne_pkg::*;

	localparam int PW = (MAX_STEPS > 1) ? $clog2(MAX_STEPS) : 1;
	localparam int TABLE = NUM_SCALES * SCALE_LEN;
	localparam int TW = $clog2(TABLE);

	typedef enum logic [10:0] {
		ST_IDLE  = 11'b00000000001,
		ST_EXEC  = 11'b00000000010,
		ST_MOD   = 11'b00000000100,
		ST_AUTO  = 11'b00000001000,
		ST_PICK  = 11'b00000010000,
		ST_MUL   = 11'b00000100000,
		ST_DIVGO = 11'b00001000000,
		ST_DIV   = 11'b00010000000,
		ST_LOOK  = 11'b00100000000,
		ST_PLAY  = 11'b01000000000,
		ST_DONE  = 11'b10000000000
	} state_t;

	typedef enum logic [1:0] {
		FLD_NOTE = 2'd0,
		FLD_VEL  = 2'd1,
		FLD_FILT = 2'd2
	} fld_t;

	state_t            state_q;
	in_t               item_q;
	logic [PW-1:0]     ptr_q;
	logic [PW-1:0]     playhead_q;
	logic              sounding_q;
	logic [4:0]        ticks_q;
	logic              on_q;
	logic              off_q;
	logic [6:0]        midi_q;
	logic [1:0]        status_q;
	logic [2:0]        pend_q;
	fld_t              fsel_q;
	logic [DIV_DW-1:0] prod_q;
	out_t              out_q;
	logic              out_valid_q;
	logic [4:0]        step_length_q;
	logic [2:0]        scale_select_q;

	logic [7:0]        len8;
	logic              bad_len;
	logic              bad_tab;
	step_t             rd;
	step_t             swd;
	step_wr_t          swr;
	logic              div_start;
	logic [DIV_DW-1:0] div_dividend;
	logic [DIV_VW-1:0] div_divisor;
	logic              div_done;
	logic [DIV_DW-1:0] div_quo;
	logic [DIV_VW-1:0] div_rem;
	logic              sc_we;
	logic [TW-1:0]     sc_raddr;
	logic [7:0]        sc_rdata;
	logic [11:0]       mulc;
	logic [2:0]        row;
	logic [4:0]        col;
	logic [8:0]        midi_sum;
	logic              out_free;

	// Configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_length_q  <= STEP_LENGTH_RESET;
			scale_select_q <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_STEP_LENGTH:  step_length_q  <= cfg_data;
				REG_SCALE_SELECT: scale_select_q <= cfg_data[2:0];
				default: ;
			endcase
		end
	end

	// Effective pattern length and range checks
	always_comb begin
		if (step_length_q == '0) begin
			len8 = 8'd1;
		end else if (int'(step_length_q) > MAX_STEPS) begin
			len8 = 8'(MAX_STEPS);
		end else begin
			len8 = 8'(step_length_q);
		end
		bad_len = item_q.step_number >= len8;
		bad_tab = int'(item_q.step_number) >= TABLE;
	end

	// Scale lookup address for the note of the addressed step
	always_comb begin
		row = (int'(scale_select_q) < NUM_SCALES) ? scale_select_q : '0;
		col = (int'(rd.note) < SCALE_LEN) ? rd.note : '0;
		sc_raddr = TW'(int'(row) * SCALE_LEN + int'(col));
		midi_sum = BASE_NOTE + 9'(sc_rdata);
	end

	// Sensor scale factor of the field being mapped
	always_comb begin
		case (fsel_q)
			FLD_NOTE: mulc = MUL_NOTE;
			FLD_VEL:  mulc = MUL_VEL;
			FLD_FILT: mulc = MUL_FILT;
			default:  mulc = MUL_NOTE;
		endcase
	end

	// Divider operands: length modulo or sensor divide
	always_comb begin
		div_start = 1'b0;
		div_dividend = prod_q;
		div_divisor = DIV_VW'(SENSOR_DIV);
		if (state_q == ST_EXEC && item_q.mode == MODE_CLOCK) begin
			div_start = 1'b1;
			div_dividend = DIV_DW'(item_q.step_number);
			div_divisor = DIV_VW'(len8);
		end else if (state_q == ST_DIVGO) begin
			div_start = 1'b1;
		end
	end

	// Step store write strobes and data
	always_comb begin
		swr = '0;
		swd = rd;
		sc_we = 1'b0;
		if (state_q == ST_EXEC) begin
			case (item_q.mode)
				MODE_WRITE: begin
					swr.all = !bad_len && (item_q.note_in <= NOTE_MAX);
					swd = '{gate: item_q.gate_in, slide: item_q.slide_in,
						note: item_q.note_in, velocity: item_q.velocity_in,
						filter: item_q.data_value};
				end
				MODE_TOGGLE: swr.tgl = !bad_len;
				MODE_SCALE: begin
					sc_we = !bad_tab && (int'(item_q.data_value) <= SCALE_VAL_MAX);
				end
				default: ;
			endcase
		end else if (state_q == ST_DIV && div_done) begin
			case (fsel_q)
				FLD_NOTE: begin
					swr.note = 1'b1;
					swd.note = (div_quo > DIV_DW'(NOTE_MAX)) ? '0 : div_quo[4:0];
				end
				FLD_VEL: begin
					swr.vel = 1'b1;
					swd.velocity = (div_quo > DIV_DW'(VEL_MAX)) ? VEL_MAX : div_quo[6:0];
				end
				FLD_FILT: begin
					swr.filt = 1'b1;
					swd.filter = (div_quo > DIV_DW'(FILT_LIMIT)) ? FILT_FALLBACK
						: div_quo[12:0];
				end
				default: ;
			endcase
		end
	end

	assign out_free = !out_valid_q || out_ready;

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			ptr_q       <= '0;
			playhead_q  <= '0;
			sounding_q  <= 1'b0;
			ticks_q     <= '0;
			on_q        <= 1'b0;
			off_q       <= 1'b0;
			midi_q      <= '0;
			status_q    <= STATUS_OK;
			pend_q      <= '0;
			fsel_q      <= FLD_NOTE;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						on_q     <= 1'b0;
						off_q    <= 1'b0;
						midi_q   <= '0;
						status_q <= STATUS_OK;
						ptr_q    <= (in_data.mode == MODE_CLOCK) ? playhead_q
							: PW'(in_data.step_number);
						state_q  <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					ptr_q   <= playhead_q;
					state_q <= ST_DONE;
					case (item_q.mode)
						MODE_CLOCK: begin
							// Release unless the old step slides into the next
							if (sounding_q && !rd.slide) begin
								off_q      <= 1'b1;
								sounding_q <= 1'b0;
								ticks_q    <= '0;
							end
							state_q <= ST_MOD;
						end
						MODE_TICK: begin
							if (sounding_q && ticks_q != '0) begin
								ticks_q <= ticks_q - 1'b1;
								if (ticks_q == 5'd1) begin
									off_q      <= 1'b1;
									sounding_q <= 1'b0;
								end
							end
						end
						MODE_WRITE: begin
							if (bad_len) begin
								status_q <= STATUS_BAD_INDEX;
							end else if (item_q.note_in > NOTE_MAX) begin
								status_q <= STATUS_BAD_VALUE;
							end
						end
						MODE_TOGGLE: begin
							if (bad_len) begin
								status_q <= STATUS_BAD_INDEX;
							end
						end
						MODE_SCALE: begin
							if (bad_tab) begin
								status_q <= STATUS_BAD_INDEX;
							end else if (int'(item_q.data_value) > SCALE_VAL_MAX) begin
								status_q <= STATUS_BAD_VALUE;
							end
						end
						default: ;
					endcase
				end
				ST_MOD: begin
					if (div_done) begin
						playhead_q <= PW'(div_rem);
						ptr_q      <= PW'(div_rem);
						state_q    <= ST_AUTO;
					end
				end
				ST_AUTO: begin
					pend_q  <= (!item_q.edit_active && rd.gate)
						? {item_q.hold_filter, item_q.hold_velocity, item_q.hold_note}
						: 3'b000;
					state_q <= ST_PICK;
				end
				ST_PICK: begin
					// Map held buttons in order: note, velocity, filter
					if (pend_q[0]) begin
						fsel_q    <= FLD_NOTE;
						pend_q[0] <= 1'b0;
						state_q   <= ST_MUL;
					end else if (pend_q[1]) begin
						fsel_q    <= FLD_VEL;
						pend_q[1] <= 1'b0;
						state_q   <= ST_MUL;
					end else if (pend_q[2]) begin
						fsel_q    <= FLD_FILT;
						pend_q[2] <= 1'b0;
						state_q   <= ST_MUL;
					end else begin
						state_q <= ST_LOOK;
					end
				end
				ST_MUL:   state_q <= ST_DIVGO;
				ST_DIVGO: state_q <= ST_DIV;
				ST_DIV: begin
					if (div_done) begin
						state_q <= ST_PICK;
					end
				end
				ST_LOOK: begin
					if (rd.gate) begin
						state_q <= ST_PLAY;
					end else begin
						if (sounding_q) begin
							off_q      <= 1'b1;
							sounding_q <= 1'b0;
							ticks_q    <= '0;
						end
						state_q <= ST_DONE;
					end
				end
				ST_PLAY: begin
					midi_q     <= (midi_sum > MIDI_MAX) ? MIDI_MAX[6:0] : midi_sum[6:0];
					sounding_q <= 1'b1;
					ticks_q    <= NOTE_TICKS;
					on_q       <= 1'b1;
					state_q    <= ST_DONE;
				end
				ST_DONE: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Item and product registers
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_valid) begin
			item_q <= in_data;
		end
		if (state_q == ST_MUL) begin
			prod_q <= DIV_DW'(item_q.sensor_mm) * DIV_DW'(mulc);
		end
	end

	// Result register
	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && out_free) begin
			out_q <= '{note_on: on_q, note_off: off_q, midi_note: midi_q,
				velocity_out: rd.velocity, filter_out: rd.filter,
				gate_out: rd.gate, slide_out: rd.slide, note_index: rd.note,
				playhead_out: 4'(playhead_q), status: status_q};
		end
	end

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	ssne_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (div_dividend),
		.divisor   (div_divisor),
		.done      (div_done),
		.quotient  (div_quo),
		.remainder (div_rem)
	);

	ssne_steps #(
		.MAX_STEPS (MAX_STEPS),
		.PW        (PW)
	) u_steps (
		.clk    (clk),
		.arst_n (arst_n),
		.addr   (ptr_q),
		.wr     (swr),
		.wdata  (swd),
		.rdata  (rd)
	);

	ssne_scale #(
		.DEPTH (TABLE),
		.AW    (TW)
	) u_scale (
		.clk   (clk),
		.we    (sc_we),
		.waddr (TW'(item_q.step_number)),
		.wdata (item_q.data_value[7:0]),
		.raddr (sc_raddr),
		.rdata (sc_rdata)
	);

	`include "step_sequencer_note_engine_unit_assert.svh"

	`SSNE_ASSERT(a_one_item, in_valid && in_ready |=> !in_ready, "second item taken while busy")
	`SSNE_NEVER(a_ticks_silent, ticks_q != 5'd0 && !sounding_q, "tick count left on a silent note")
	`SSNE_ASSERT(a_on_gated, out_valid && out_data.note_on |-> out_data.gate_out, "note started on a rest")
	`SSNE_ASSERT(a_midi_idle, out_valid && !out_data.note_on |-> out_data.midi_note == 7'd0, "stray midi note")
	`SSNE_ASSERT(a_err_quiet, out_valid && out_data.status != STATUS_OK |-> !out_data.note_on && !out_data.note_off, "note event on a rejected item")

endmodule
